@@ rtl/tpc_pkg.sv @@
// Package for the three-wheel PI current controller.
// Holds constants, register indexes, multiplier codes and the control/status words.
// Depends on nothing.
package tpc_pkg;

    localparam int WHEEL_COUNT_DEF = 3;
    localparam int OUT_WHEELS      = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PROP_GAIN   = 3'd0;
    localparam t_cfg_idx CFG_INTEG_GAIN  = 3'd1;
    localparam t_cfg_idx CFG_CURR_LIMIT  = 3'd2;
    localparam t_cfg_idx CFG_SPEED_SCALE = 3'd3;
    localparam t_cfg_idx CFG_FIRST_ID    = 3'd4;
    localparam t_cfg_idx CFG_NOMINAL_DT  = 3'd5;

    localparam logic [15:0] PROP_GAIN_RST   = 16'd500;
    localparam logic [15:0] INTEG_GAIN_RST  = 16'd5000;
    localparam logic [13:0] CURR_LIMIT_RST  = 14'd10000;
    localparam logic [15:0] SPEED_SCALE_RST = 16'd48803;
    localparam logic [3:0]  FIRST_ID_RST    = 4'd1;
    localparam logic [14:0] NOMINAL_DT_RST  = 15'd1000;

    localparam logic [11:0] FRAME_BASE_ID   = 12'h200;
    localparam logic [3:0]  MIN_FRAME_BYTES = 4'd6;
    localparam logic [14:0] DT_MIN_US       = 15'd500;
    localparam logic [14:0] DT_MAX_US       = 15'd20000;
    localparam logic [13:0] OUT_LIMIT_MA    = 14'd10000;

    // integral scaling: Ki * e * dt * 1024 / 15625
    localparam int DIV_DEN   = 15625;
    localparam int DIV_HALF  = DIV_DEN / 2;
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = 8;
    localparam int DIV_REM_W = 14;
    localparam int QUO_W     = 44;

    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_NONE = 3'd0;
    localparam t_mul_sel MUL_FB   = 3'd1;
    localparam t_mul_sel MUL_IG   = 3'd2;
    localparam t_mul_sel MUL_DT   = 3'd3;
    localparam t_mul_sel MUL_PE   = 3'd4;

    typedef struct packed {
        logic     capture;
        t_mul_sel mul_sel;
        logic     fb_write;
        logic     tick_start;
        logic     zero_integ;
        logic     err_calc;
        logic     div_start;
        logic     int_write;
        logic     cmd_write;
        logic     emit;
        logic     emit_last;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic armed;
        logic armed_before;
        logic fb_hit;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

@@ rtl/tpc_div.sv @@
// Iterative divider by a fixed constant, several quotient bits per cycle.
// Depends on tpc_pkg.
module tpc_div import tpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    output logic             o_busy,
    output logic [QUO_W-1:0] o_quotient
);

    localparam int CYCLES = DIV_W / DIV_STEPS;
    localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;
    localparam logic [DIV_REM_W:0]  DEN  = (DIV_REM_W + 1)'(DIV_DEN);
    localparam logic [CNT_W-1:0]    LAST = CNT_W'(CYCLES - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_W-1:0]     r_sh;
    logic [DIV_REM_W-1:0] n_rem;
    logic [DIV_W-1:0]     n_sh;
    logic [DIV_REM_W:0]   trial;

    always_comb begin
        n_rem = r_rem;
        n_sh  = r_sh;
        trial = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {n_rem, n_sh[DIV_W-1]};
            n_sh  = {n_sh[DIV_W-2:0], 1'b0};
            if (trial >= DEN) begin
                n_rem   = DIV_REM_W'(trial - DEN);
                n_sh[0] = 1'b1;
            end else begin
                n_rem = trial[DIV_REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= n_sh;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_sh[QUO_W-1:0];

endmodule

@@ rtl/tpc_dp.sv @@
// Datapath: configuration, wheel state, shared multiplier, divider and result register.
// Depends on tpc_pkg and tpc_div.
module tpc_dp import tpc_pkg::*; #(
    parameter int WHEEL_COUNT = WHEEL_COUNT_DEF,
    localparam int WI_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_operation,
    input  logic [10:0]           i_frame_id,
    input  logic [3:0]            i_frame_length,
    input  logic signed [15:0]    i_rotor_rpm,
    input  logic                  i_armed,
    input  logic signed [15:0]    i_target_speed_0,
    input  logic signed [15:0]    i_target_speed_1,
    input  logic signed [15:0]    i_target_speed_2,
    input  logic [15:0]           i_elapsed_us,
    input  t_cmd                  i_cmd,
    input  logic [WI_W-1:0]       i_wheel,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [14:0]    o_current_cmd_0,
    output logic signed [14:0]    o_current_cmd_1,
    output logic signed [14:0]    o_current_cmd_2,
    output logic                  o_last_of_run
);

    localparam int CMD_N = (WHEEL_COUNT < OUT_WHEELS) ? WHEEL_COUNT : OUT_WHEELS;
    localparam int MA_W  = 33;
    localparam int MB_W  = 18;
    localparam int MP_W  = 51;

    logic [15:0] r_prop_gain, r_integ_gain, r_speed_scale;
    logic [13:0] r_limit;
    logic [3:0]  r_first_id;
    logic [14:0] r_nominal_dt;

    logic               r_op, r_armed;
    logic [10:0]        r_fid;
    logic [3:0]         r_flen;
    logic signed [15:0] r_rpm;
    logic signed [15:0] r_tgt [OUT_WHEELS];
    logic [15:0]        r_elapsed;

    logic signed [15:0] r_speed  [WHEEL_COUNT];
    logic signed [39:0] r_integ  [WHEEL_COUNT];
    logic               r_online [WHEEL_COUNT];
    logic signed [14:0] r_cmd    [CMD_N];
    logic               r_armed_before, r_ticked;

    logic signed [MP_W-1:0] r_prod;
    logic signed [33:0]     r_pe;
    logic signed [16:0]     r_err;
    logic [15:0]            r_emag;
    logic                   r_eneg;
    logic [14:0]            r_dt;

    logic               r_out_valid, r_out_last;
    logic signed [14:0] r_out_cmd [OUT_WHEELS];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= PROP_GAIN_RST;
            r_integ_gain  <= INTEG_GAIN_RST;
            r_limit       <= CURR_LIMIT_RST;
            r_speed_scale <= SPEED_SCALE_RST;
            r_first_id    <= FIRST_ID_RST;
            r_nominal_dt  <= NOMINAL_DT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                CFG_CURR_LIMIT:  r_limit       <= i_cfg_data[13:0];
                CFG_SPEED_SCALE: r_speed_scale <= i_cfg_data;
                CFG_FIRST_ID:    r_first_id    <= i_cfg_data[3:0];
                CFG_NOMINAL_DT:  r_nominal_dt  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_operation;
            r_fid     <= i_frame_id;
            r_flen    <= i_frame_length;
            r_rpm     <= i_rotor_rpm;
            r_armed   <= i_armed;
            r_tgt[0]  <= i_target_speed_0;
            r_tgt[1]  <= i_target_speed_1;
            r_tgt[2]  <= i_target_speed_2;
            r_elapsed <= i_elapsed_us;
        end
    end

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_FB: begin
                mul_a = {{(MA_W-16){r_rpm[15]}}, r_rpm};
                mul_b = {2'b00, r_speed_scale};
            end
            MUL_IG: begin
                mul_a = {17'd0, r_integ_gain};
                mul_b = {2'b00, r_emag};
            end
            MUL_DT: begin
                mul_a = {1'b0, r_prod[31:0]};
                mul_b = {3'b000, r_dt};
            end
            MUL_PE: begin
                mul_a = {17'd0, r_prop_gain};
                mul_b = {r_err[16], r_err};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel == MUL_FB || i_cmd.mul_sel == MUL_IG || i_cmd.mul_sel == MUL_DT) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_sel == MUL_PE) begin
            r_pe <= mul_p[33:0];
        end
    end

    // feedback decode and speed rounding
    logic [11:0]        fb_diff;
    logic               fb_hit;
    logic [WI_W-1:0]    fb_idx;
    logic [32:0]        fb_mag, fb_sum;
    logic [16:0]        fb_q;
    logic signed [15:0] fb_speed;

    assign fb_diff = {1'b0, r_fid} - FRAME_BASE_ID - {8'd0, r_first_id};
    assign fb_hit  = (r_flen >= MIN_FRAME_BYTES) && !fb_diff[11]
                     && (fb_diff < 12'(WHEEL_COUNT));
    assign fb_idx  = fb_diff[WI_W-1:0];
    assign fb_mag  = r_prod[MP_W-1] ? 33'(-r_prod[32:0]) : r_prod[32:0];
    assign fb_sum  = fb_mag + 33'd32768;
    assign fb_q    = fb_sum[32:16];

    always_comb begin
        if (r_prod[MP_W-1]) begin
            fb_speed = 16'(-fb_q);
        end else if (fb_q > 17'd32767) begin
            fb_speed = 16'sh7FFF;
        end else begin
            fb_speed = fb_q[15:0];
        end
    end

    // per-wheel error
    logic signed [15:0] w_speed, w_tgt;
    logic signed [39:0] w_integ;
    logic               w_online;
    logic signed [16:0] err;

    assign w_speed  = r_speed[i_wheel];
    assign w_integ  = r_integ[i_wheel];
    assign w_online = r_online[i_wheel];

    always_comb begin
        w_tgt = '0;
        for (int k = 0; k < CMD_N; k++) begin
            if (i_wheel == WI_W'(k)) begin
                w_tgt = r_tgt[k];
            end
        end
    end

    assign err = {w_tgt[15], w_tgt} - {w_speed[15], w_speed};

    always_ff @(posedge i_clk) begin
        if (i_cmd.err_calc) begin
            r_err  <= err;
            r_eneg <= err[16];
            r_emag <= err[16] ? 16'(-err) : err[15:0];
        end
    end

    // time step
    logic [15:0] dt_raw;

    assign dt_raw = r_ticked ? r_elapsed : {1'b0, r_nominal_dt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            if (dt_raw < {1'b0, DT_MIN_US}) begin
                r_dt <= DT_MIN_US;
            end else if (dt_raw > {1'b0, DT_MAX_US}) begin
                r_dt <= DT_MAX_US;
            end else begin
                r_dt <= dt_raw[14:0];
            end
        end
    end

    // integral scaling
    logic [DIV_W-1:0] div_num;
    logic [QUO_W-1:0] div_quo;
    logic             div_busy;

    assign div_num = DIV_W'({r_prod[46:0], 10'd0}) + DIV_W'(DIV_HALF);

    tpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // integrator update
    logic [45:0]        inc_mag;
    logic signed [45:0] inc_s, isum, lim_i, iclamp;
    logic signed [39:0] new_integ;

    assign inc_mag = {2'b00, div_quo};
    assign inc_s   = r_eneg ? -$signed(inc_mag) : $signed(inc_mag);
    assign isum    = $signed({{6{w_integ[39]}}, w_integ}) + inc_s;
    assign lim_i   = $signed({8'd0, r_limit, 24'd0});

    always_comb begin
        if (isum > lim_i) begin
            iclamp = lim_i;
        end else if (isum < -lim_i) begin
            iclamp = -lim_i;
        end else begin
            iclamp = isum;
        end
    end

    assign new_integ = w_online ? iclamp[39:0] : '0;

    // command
    logic signed [50:0] c_sum, lim_c, c_cl, c_adj;
    logic signed [26:0] c_ma, olim, c_out;
    logic [13:0]        outlim;

    assign c_sum  = $signed({r_pe[33], r_pe, 16'd0}) + $signed({{11{w_integ[39]}}, w_integ});
    assign lim_c  = $signed({13'd0, r_limit, 24'd0});
    assign outlim = (r_limit < OUT_LIMIT_MA) ? r_limit : OUT_LIMIT_MA;
    assign olim   = $signed({13'd0, outlim});

    always_comb begin
        if (c_sum > lim_c) begin
            c_cl = lim_c;
        end else if (c_sum < -lim_c) begin
            c_cl = -lim_c;
        end else begin
            c_cl = c_sum;
        end
    end

    // truncate toward zero
    assign c_adj = c_cl + (c_cl[50] ? $signed({27'd0, 24'hFF_FFFF}) : 51'sd0);
    assign c_ma  = c_adj[50:24];

    always_comb begin
        if (c_ma > olim) begin
            c_out = olim;
        end else if (c_ma < -olim) begin
            c_out = -olim;
        end else begin
            c_out = c_ma;
        end
    end

    // wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WHEEL_COUNT; k++) begin
                r_speed[k]  <= '0;
                r_integ[k]  <= '0;
                r_online[k] <= 1'b0;
            end
            r_armed_before <= 1'b0;
            r_ticked       <= 1'b0;
        end else begin
            if (i_cmd.fb_write) begin
                r_speed[fb_idx]  <= fb_speed;
                r_online[fb_idx] <= 1'b1;
            end
            if (i_cmd.tick_start) begin
                r_armed_before <= r_armed;
                r_ticked       <= 1'b1;
            end
            if (i_cmd.zero_integ) begin
                for (int k = 0; k < WHEEL_COUNT; k++) begin
                    r_integ[k] <= '0;
                end
            end else if (i_cmd.int_write) begin
                r_integ[i_wheel] <= new_integ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmd_write && (i_wheel < WI_W'(CMD_N))) begin
            r_cmd[i_wheel] <= c_out[14:0];
        end
    end

    // result register
    logic signed [14:0] out_next [OUT_WHEELS];
    logic               out_free;

    always_comb begin
        for (int k = 0; k < OUT_WHEELS; k++) begin
            out_next[k] = '0;
        end
        for (int k = 0; k < CMD_N; k++) begin
            if (r_armed) begin
                out_next[k] = r_cmd[k];
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int k = 0; k < OUT_WHEELS; k++) begin
                r_out_cmd[k] <= out_next[k];
            end
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_current_cmd_0 = r_out_cmd[0];
    assign o_current_cmd_1 = r_out_cmd[1];
    assign o_current_cmd_2 = r_out_cmd[2];
    assign o_last_of_run   = r_out_last;

    assign o_status.op           = r_op;
    assign o_status.armed        = r_armed;
    assign o_status.armed_before = r_armed_before;
    assign o_status.fb_hit       = fb_hit;
    assign o_status.div_busy     = div_busy;
    assign o_status.out_free     = out_free;

`ifndef ASSERT_OFF
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cmd[0] <= 15'sd10000) && (r_out_cmd[0] >= -15'sd10000))
        else $error("command word out of range");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |->
            (r_out_cmd[0] == 15'sd0) && (r_out_cmd[1] == 15'sd0) && (r_out_cmd[2] == 15'sd0))
        else $error("non-final word of a tick carries a command");

    a_integ_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.zero_integ |=> (r_integ[0] == 40'sd0))
        else $error("integrator not cleared on disarm");
`endif

endmodule

@@ rtl/tpc_ctrl.sv @@
// Controller: sequences feedback updates and the per-wheel PI steps of a tick.
// Depends on tpc_pkg; drives the datapath through t_cmd.
module tpc_ctrl import tpc_pkg::*; #(
    parameter int WHEEL_COUNT = WHEEL_COUNT_DEF,
    localparam int WI_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_status         i_st,
    output t_cmd            o_cmd,
    output logic [WI_W-1:0] o_wheel
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_FB_MUL   = 4'd2;
    localparam logic [3:0] S_FB_WR    = 4'd3;
    localparam logic [3:0] S_TICK     = 4'd4;
    localparam logic [3:0] S_ERR      = 4'd5;
    localparam logic [3:0] S_M_IG     = 4'd6;
    localparam logic [3:0] S_M_DT     = 4'd7;
    localparam logic [3:0] S_DIV_GO   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_INT      = 4'd10;
    localparam logic [3:0] S_CMD      = 4'd11;
    localparam logic [3:0] S_OUT_A    = 4'd12;
    localparam logic [3:0] S_OUT_B    = 4'd13;

    localparam logic [WI_W-1:0] LAST_WHEEL = WI_W'(WHEEL_COUNT - 1);

    logic [3:0]      r_state, n_state;
    logic [WI_W-1:0] r_wheel, n_wheel;
    t_cmd            c;

    always_comb begin
        n_state = r_state;
        n_wheel = r_wheel;
        c       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c.capture = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_st.op) begin
                    n_state = S_TICK;
                end else if (i_st.fb_hit) begin
                    n_state = S_FB_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FB_MUL: begin
                c.mul_sel = MUL_FB;
                n_state   = S_FB_WR;
            end
            S_FB_WR: begin
                c.fb_write = 1'b1;
                n_state    = S_IDLE;
            end
            S_TICK: begin
                c.tick_start = 1'b1;
                n_wheel      = '0;
                if (i_st.armed) begin
                    n_state = S_ERR;
                end else begin
                    c.zero_integ = 1'b1;
                    n_state      = i_st.armed_before ? S_OUT_A : S_OUT_B;
                end
            end
            S_ERR: begin
                c.err_calc = 1'b1;
                n_state    = S_M_IG;
            end
            S_M_IG: begin
                c.mul_sel = MUL_IG;
                n_state   = S_M_DT;
            end
            S_M_DT: begin
                c.mul_sel = MUL_DT;
                n_state   = S_DIV_GO;
            end
            S_DIV_GO: begin
                c.div_start = 1'b1;
                c.mul_sel   = MUL_PE;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_st.div_busy) begin
                    n_state = S_INT;
                end
            end
            S_INT: begin
                c.int_write = 1'b1;
                n_state     = S_CMD;
            end
            S_CMD: begin
                c.cmd_write = 1'b1;
                if (r_wheel == LAST_WHEEL) begin
                    n_state = S_OUT_B;
                end else begin
                    n_wheel = r_wheel + 1'b1;
                    n_state = S_ERR;
                end
            end
            S_OUT_A: begin
                if (i_st.out_free) begin
                    c.emit  = 1'b1;
                    n_state = S_OUT_B;
                end
            end
            S_OUT_B: begin
                if (i_st.out_free) begin
                    c.emit      = 1'b1;
                    c.emit_last = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wheel <= '0;
        end else begin
            r_state <= n_state;
            r_wheel <= n_wheel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = c;
    assign o_wheel    = r_wheel;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.emit |-> i_st.out_free)
        else $error("word issued into an occupied result register");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.div_start |-> !i_st.div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

@@ rtl/three_wheel_pi_current_controller.sv @@
// Channel   Handshake                  Carries
// input     i_in_valid / o_in_stall    feedback frame or control tick, one word
// output    o_out_valid / i_out_stall  wheel current commands and last_of_run
// config    i_cfg_we                   register write, i_cfg_index / i_cfg_data
//
// Feedback word: captured, decoded, scaled on the shared multiplier, then written.
// Control tick: per wheel an error, two products on the shared multiplier, the integral
// divider alongside the proportional product, then the integrator and command writes.
// A new word is taken while a finished result waits in the output register.
// Reset: synchronous, active low; no clearing pass, ready on the cycle after reset.
// Depends on tpc_pkg, tpc_ctrl, tpc_dp, tpc_div.
module three_wheel_pi_current_controller import tpc_pkg::*; #(
    parameter int WHEEL_COUNT = WHEEL_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [10:0]           i_frame_id,
    input  logic [3:0]            i_frame_length,
    input  logic signed [15:0]    i_rotor_rpm,
    input  logic                  i_armed,
    input  logic signed [15:0]    i_target_speed_0,
    input  logic signed [15:0]    i_target_speed_1,
    input  logic signed [15:0]    i_target_speed_2,
    input  logic [15:0]           i_elapsed_us,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [14:0]    o_current_cmd_0,
    output logic signed [14:0]    o_current_cmd_1,
    output logic signed [14:0]    o_current_cmd_2,
    output logic                  o_last_of_run
);

    localparam int WI_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

    t_cmd            cmd;
    t_status         st;
    logic [WI_W-1:0] wheel;

    tpc_ctrl #(
        .WHEEL_COUNT (WHEEL_COUNT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_wheel    (wheel)
    );

    tpc_dp #(
        .WHEEL_COUNT (WHEEL_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_frame_id       (i_frame_id),
        .i_frame_length   (i_frame_length),
        .i_rotor_rpm      (i_rotor_rpm),
        .i_armed          (i_armed),
        .i_target_speed_0 (i_target_speed_0),
        .i_target_speed_1 (i_target_speed_1),
        .i_target_speed_2 (i_target_speed_2),
        .i_elapsed_us     (i_elapsed_us),
        .i_cmd            (cmd),
        .i_wheel          (wheel),
        .o_status         (st),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_current_cmd_0  (o_current_cmd_0),
        .o_current_cmd_1  (o_current_cmd_1),
        .o_current_cmd_2  (o_current_cmd_2),
        .o_last_of_run    (o_last_of_run)
    );

endmodule
